// ===== src/pcie_config_bridge_registers_unit_macros.svh =====
// Assertion macros for the configuration bridge register block.
// Used by the checker; expects clk_i and rst_ni in the including scope.
`ifndef PCIE_CONFIG_BRIDGE_REGISTERS_UNIT_MACROS_SVH
`define PCIE_CONFIG_BRIDGE_REGISTERS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcbr_pkg.sv =====
// Shared types and constants of the configuration bridge register block.
// No dependencies.
package pcbr_pkg;

  localparam int REG_WORDS = 64;
  localparam int IDX_W     = 6;
  localparam int DATA_W    = 32;

  // item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_PIN   = 2'd2;

  // register map, word indexes
  localparam logic [IDX_W-1:0] W_CTRL      = 6'd0;
  localparam logic [IDX_W-1:0] W_TX_CLEAR  = 6'd2;
  localparam logic [IDX_W-1:0] W_RDATA     = 6'd3;
  localparam logic [IDX_W-1:0] W_DESC0     = 6'd4;
  localparam logic [IDX_W-1:0] W_DESC1     = 6'd5;
  localparam logic [IDX_W-1:0] W_DESC2     = 6'd6;
  localparam logic [IDX_W-1:0] W_TX_DATA   = 6'd8;
  localparam logic [IDX_W-1:0] W_TX_STS    = 6'd9;
  localparam logic [IDX_W-1:0] W_INT_EN    = 6'd49;
  localparam logic [IDX_W-1:0] W_INT_STS   = 6'd50;
  localparam logic [IDX_W-1:0] W_REQ_RDATA = 6'd51;

  // descriptor request type codes
  localparam logic [7:0] TYPE_WR_A = 8'h44;
  localparam logic [7:0] TYPE_WR_B = 8'h45;
  localparam logic [7:0] TYPE_RD_A = 8'h04;
  localparam logic [7:0] TYPE_RD_B = 8'h05;

  localparam logic [11:0] OFFSET_MASK  = 12'hFFC;
  localparam int          CTRL_RX_CLR  = 4;   // control: load receive data with ones
  localparam int          INT_DONE_BIT = 4;   // interrupt status: request done
  localparam logic [2:0]  READ_LEN     = 3'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [IDX_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
    logic [1:0]        pin;
    logic              pin_level;
    logic              target_present;
    logic [DATA_W-1:0] target_read_data;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic              write_op;
    logic [7:0]        bus;
    logic [7:0]        devfn;
    logic [11:0]       offset;
    logic [DATA_W-1:0] wdata;
    logic [2:0]        len;
  } req_t;

  // request builder result: the request plus its effect on word 51
  typedef struct packed {
    req_t req;
    logic rd_all_ones;
    logic rd_load;
  } req_res_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    req_t              req;
    logic              intx_level;
  } result_t;

endpackage

// ===== src/pcbr_intf.sv =====
// Valid/ready channel interfaces of the configuration bridge register block.
// No dependencies.
interface pcbr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  reg_index;
  logic [31:0] write_data;
  logic [1:0]  pin;
  logic        pin_level;
  logic        target_present;
  logic [31:0] target_read_data;

  modport source (output valid, mode, reg_index, write_data, pin, pin_level,
                  target_present, target_read_data, input ready);
  modport sink   (input valid, mode, reg_index, write_data, pin, pin_level,
                  target_present, target_read_data, output ready);
endinterface

interface pcbr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        req_valid;
  logic        req_write;
  logic [7:0]  req_bus;
  logic [7:0]  req_devfn;
  logic [11:0] req_offset;
  logic [31:0] req_wdata;
  logic [2:0]  req_len;
  logic        intx_level;

  modport source (output valid, read_data, req_valid, req_write, req_bus,
                  req_devfn, req_offset, req_wdata, req_len, intx_level,
                  input ready);
  modport sink   (input valid, read_data, req_valid, req_write, req_bus,
                  req_devfn, req_offset, req_wdata, req_len, intx_level,
                  output ready);
endinterface

interface pcbr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/pcbr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pcbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pcbr_req.sv =====
// Configuration request builder: decodes the descriptor words into a request.
// Depends on pcbr_pkg.
module pcbr_req
  import pcbr_pkg::*;
(
  input  logic [7:0]        req_type_i,
  input  logic [3:0]        byte_en_i,
  input  logic [DATA_W-1:0] desc2_i,
  input  logic [DATA_W-1:0] tx_data_i,
  input  logic [7:0]        root_bus_i,
  input  logic              present_i,
  output req_res_t          res_o
);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [2:0]        cnt;
    logic [1:0]        first;
  } pack_t;

  // pack enabled bytes down from byte zero
  function automatic pack_t pack_bytes(input logic [3:0] en, input logic [DATA_W-1:0] wd);
    pack_t p;
    logic  seen;
    p    = '0;
    seen = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (en[i]) begin
        if (!seen) begin
          p.first = 2'(i);
        end
        seen = 1'b1;
        p.data[8*p.cnt[1:0] +: 8] = wd[8*i +: 8];
        p.cnt = p.cnt + 3'd1;
      end
    end
    return p;
  endfunction

  pack_t       pk;
  logic [7:0]  bus_raw;
  logic [11:0] offset;
  logic        is_wr;
  logic        is_rd;

  always_comb begin
    pk      = pack_bytes(byte_en_i, tx_data_i);
    bus_raw = desc2_i[31:24];
    offset  = desc2_i[11:0] & OFFSET_MASK;
    is_wr   = (req_type_i == TYPE_WR_A) || (req_type_i == TYPE_WR_B);
    is_rd   = (req_type_i == TYPE_RD_A) || (req_type_i == TYPE_RD_B);

    res_o             = '0;
    res_o.rd_all_ones = !present_i;
    res_o.rd_load     = present_i && is_rd;
    res_o.req.valid   = present_i && (is_rd || (is_wr && (pk.cnt != 3'd0)));
    if (res_o.req.valid) begin
      res_o.req.write_op = is_wr;
      res_o.req.bus      = (bus_raw == root_bus_i) ? 8'd0 : bus_raw;
      res_o.req.devfn    = desc2_i[23:16];
      if (is_wr) begin
        res_o.req.offset = offset + {10'd0, pk.first};
        res_o.req.wdata  = pk.data;
        res_o.req.len    = pk.cnt;
      end else begin
        res_o.req.offset = offset;
        res_o.req.len    = READ_LEN;
      end
    end
  end

endmodule

// ===== src/pcie_config_bridge_registers_unit.sv =====
// Top level of the PCIe configuration bridge register block.
// Depends on pcbr_pkg, pcbr_intf, pcbr_ram and pcbr_req.
//
// A 64-word register file that is read and written by word index, with side
// effects on a handful of words, and that turns its descriptor words into
// PCIe configuration requests when the transmit status word is triggered.
// One item is taken every cycle while the output is not stalled, and each
// item yields exactly one result. At the accepting edge the item lands in
// the execute register and the word RAM takes its registered read (address
// straight from the input channel); decode and state update then run in the
// execute stage and land in the result register once it can take them. The
// result register decouples the output side, so a new item is accepted
// while a finished result waits, as long as the execute stage is empty. The
// side-effect words (receive data, descriptors, transmit data, transmit and
// interrupt status, interrupt enable, request read data) live in flip-flops;
// the plain words live in the RAM, whose per-word valid bits make unwritten
// words read as zero right after reset, so no clearing pass is needed.
// root_bus_number resets to 128 and is written over the cfg channel, which
// is always ready.
module pcie_config_bridge_registers_unit
  import pcbr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pcbr_in_if.sink     in_i,
  pcbr_out_if.source  out_o,
  pcbr_cfg_if.sink    cfg_i
);

  localparam int AW = $clog2(REG_WORDS);

  // ---- pipeline control ----
  logic    s1_v_q;      // item held in the execute stage
  item_t   s1_q;
  logic    out_v_q;     // result register holds an item
  result_t out_q;
  result_t out_d;

  logic adv;            // result register can take a new item
  logic s1_go;          // execute-stage item moves to the result register
  logic in_acc;

  assign adv      = !out_v_q || out_o.ready;
  assign s1_go    = s1_v_q && adv;
  assign in_i.ready = !s1_v_q || adv;
  assign in_acc   = in_i.valid && in_i.ready;

  // ---- configuration ----
  logic [7:0] root_bus_q;
  assign cfg_i.ready = 1'b1;

  // ---- side-effect words ----
  logic [DATA_W-1:0] rdata_q, rdata_d;       // word 3
  logic [DATA_W-1:0] desc0_q, desc0_d;       // word 4
  logic [DATA_W-1:0] desc1_q, desc1_d;       // word 5
  logic [DATA_W-1:0] desc2_q, desc2_d;       // word 6
  logic [DATA_W-1:0] txdata_q, txdata_d;     // word 8
  logic              idle_q, idle_d;         // word 9 bit 31
  logic              comp_q, comp_d;         // word 9 bit 25
  logic [DATA_W-1:0] inten_q, inten_d;       // word 49
  logic              done_q, done_d;         // word 50 bit 4
  logic [3:0]        intx_q, intx_d;         // word 50 bits 3..0
  logic [DATA_W-1:0] reqrd_q, reqrd_d;       // word 51
  logic              line_q, line_d;         // interrupt line

  // ---- plain word RAM with valid bits and write-to-read bypass ----
  logic [REG_WORDS-1:0] wvalid_q;
  logic                 ram_sel;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;
  logic                 rvld_q;
  logic                 byp_q;
  logic [DATA_W-1:0]    byp_data_q;
  logic [DATA_W-1:0]    ram_word;

  assign ram_we    = s1_go && (s1_q.mode == MODE_WRITE) && ram_sel;
  assign ram_waddr = s1_q.reg_index[AW-1:0];
  assign ram_raddr = in_i.reg_index[AW-1:0];

  pcbr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REG_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s1_q.write_data),
    .re_i    (in_acc),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // a write retiring in the same cycle as the read wins over the old RAM data
  assign ram_word = byp_q ? byp_data_q : (rvld_q ? ram_rdata : '0);

  // ---- request builder ----
  req_res_t req_res;

  pcbr_req u_req (
    .req_type_i (desc0_q[31:24]),
    .byte_en_i  (desc1_q[3:0]),
    .desc2_i    (desc2_q),
    .tx_data_i  (txdata_q),
    .root_bus_i (root_bus_q),
    .present_i  (s1_q.target_present),
    .res_o      (req_res)
  );

  // ---- register read mux ----
  logic [DATA_W-1:0] word_rd;

  always_comb begin
    unique case (s1_q.reg_index)
      W_CTRL,
      W_TX_CLEAR:  word_rd = '0;             // never stored
      W_RDATA:     word_rd = rdata_q;
      W_DESC0:     word_rd = desc0_q;
      W_DESC1:     word_rd = desc1_q;
      W_DESC2:     word_rd = desc2_q;
      W_TX_DATA:   word_rd = txdata_q;
      W_TX_STS:    word_rd = {idle_q, 5'd0, comp_q, 25'd0};
      W_INT_EN:    word_rd = inten_q;
      W_INT_STS:   word_rd = {27'd0, done_q, intx_q};
      W_REQ_RDATA: word_rd = reqrd_q;
      default:     word_rd = ram_word;
    endcase
  end

  // ---- execute stage ----
  always_comb begin
    rdata_d  = rdata_q;
    desc0_d  = desc0_q;
    desc1_d  = desc1_q;
    desc2_d  = desc2_q;
    txdata_d = txdata_q;
    idle_d   = idle_q;
    comp_d   = comp_q;
    inten_d  = inten_q;
    done_d   = done_q;
    intx_d   = intx_q;
    reqrd_d  = reqrd_q;
    line_d   = line_q;
    ram_sel  = 1'b0;
    out_d    = '0;

    unique case (s1_q.mode)
      MODE_READ: begin
        out_d.read_data = word_rd;
      end
      MODE_WRITE: begin
        unique case (s1_q.reg_index)
          W_CTRL: begin
            if (s1_q.write_data[CTRL_RX_CLR]) begin
              rdata_d = '1;
            end
          end
          W_TX_CLEAR: begin
            if (s1_q.write_data[0]) begin
              idle_d = 1'b0;
            end
          end
          W_TX_STS: begin
            // trigger: issue the request, then flag done/complete/idle
            if (s1_q.write_data[0]) begin
              if (req_res.rd_all_ones) begin
                reqrd_d = '1;
              end else if (req_res.rd_load) begin
                reqrd_d = s1_q.target_read_data;
              end
              out_d.req = req_res.req;
              done_d    = 1'b1;
              comp_d    = 1'b1;
              idle_d    = 1'b1;
            end
          end
          W_INT_STS: begin
            // write-one-to-clear; INTx bits follow the pins only
            if (s1_q.write_data[INT_DONE_BIT]) begin
              comp_d = 1'b0;
              done_d = 1'b0;
            end
          end
          W_RDATA:     rdata_d  = s1_q.write_data;
          W_DESC0:     desc0_d  = s1_q.write_data;
          W_DESC1:     desc1_d  = s1_q.write_data;
          W_DESC2:     desc2_d  = s1_q.write_data;
          W_TX_DATA:   txdata_d = s1_q.write_data;
          W_INT_EN:    inten_d  = s1_q.write_data;
          W_REQ_RDATA: reqrd_d  = s1_q.write_data;
          default:     ram_sel  = 1'b1;
        endcase
      end
      MODE_PIN: begin
        intx_d[s1_q.pin] = s1_q.pin_level;
        line_d = |({done_q, intx_d} & inten_q[4:0]);
      end
      default: ;                             // unused mode: no effect
    endcase

    out_d.intx_level = line_d;
  end

  // ---- control and state registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      out_v_q    <= 1'b0;
      root_bus_q <= 8'd128;
      wvalid_q   <= '0;
      rvld_q     <= 1'b0;
      byp_q      <= 1'b0;
      rdata_q    <= '0;
      desc0_q    <= '0;
      desc1_q    <= '0;
      desc2_q    <= '0;
      txdata_q   <= '0;
      idle_q     <= 1'b0;
      comp_q     <= 1'b0;
      inten_q    <= '0;
      done_q     <= 1'b0;
      intx_q     <= '0;
      reqrd_q    <= '0;
      line_q     <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        root_bus_q <= cfg_i.data;
      end
      if (in_acc) begin
        s1_v_q <= 1'b1;
        rvld_q <= wvalid_q[ram_raddr] || (ram_we && (ram_waddr == ram_raddr));
        byp_q  <= ram_we && (ram_waddr == ram_raddr);
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (ram_we) begin
        wvalid_q[ram_waddr] <= 1'b1;
      end
      if (s1_go) begin
        rdata_q  <= rdata_d;
        desc0_q  <= desc0_d;
        desc1_q  <= desc1_d;
        desc2_q  <= desc2_d;
        txdata_q <= txdata_d;
        idle_q   <= idle_d;
        comp_q   <= comp_d;
        inten_q  <= inten_d;
        done_q   <= done_d;
        intx_q   <= intx_d;
        reqrd_q  <= reqrd_d;
        line_q   <= line_d;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.mode             <= in_i.mode;
      s1_q.reg_index        <= in_i.reg_index;
      s1_q.write_data       <= in_i.write_data;
      s1_q.pin              <= in_i.pin;
      s1_q.pin_level        <= in_i.pin_level;
      s1_q.target_present   <= in_i.target_present;
      s1_q.target_read_data <= in_i.target_read_data;
      byp_data_q            <= s1_q.write_data;
    end
    if (s1_go) begin
      out_q <= out_d;
    end
  end

  // ---- result channel ----
  assign out_o.valid        = out_v_q;
  assign out_o.read_data    = out_q.read_data;
  assign out_o.req_valid    = out_q.req.valid;
  assign out_o.req_write    = out_q.req.write_op;
  assign out_o.req_bus      = out_q.req.bus;
  assign out_o.req_devfn    = out_q.req.devfn;
  assign out_o.req_offset   = out_q.req.offset;
  assign out_o.req_wdata    = out_q.req.wdata;
  assign out_o.req_len      = out_q.req.len;
  assign out_o.intx_level   = out_q.intx_level;

endmodule

// ===== src/pcbr_checker.sv =====
// Port-level checks of the configuration bridge register block, bound to the top.
// Depends on pcbr_intf and the block's assertion macros.
`include "pcie_config_bridge_registers_unit_macros.svh"

module pcbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] read_data_i,
  input logic        req_valid_i,
  input logic        req_write_i,
  input logic [7:0]  req_bus_i,
  input logic [7:0]  req_devfn_i,
  input logic [11:0] req_offset_i,
  input logic [31:0] req_wdata_i,
  input logic [2:0]  req_len_i,
  input logic        intx_level_i
);

  logic        in_acc;
  logic        out_stall;
  logic [97:0] out_word;
  logic        req_none;
  logic        req_zero;
  logic        rd_req;
  logic        rd_shape;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_word  = {read_data_i, req_valid_i, req_write_i, req_bus_i, req_devfn_i,
                      req_offset_i, req_wdata_i, req_len_i, intx_level_i};
  assign req_none  = out_valid_i && !req_valid_i;
  assign req_zero  = !req_write_i && (req_bus_i == 8'd0) && (req_devfn_i == 8'd0) &&
                     (req_offset_i == 12'd0) && (req_wdata_i == 32'd0) &&
                     (req_len_i == 3'd0);
  assign rd_req    = out_valid_i && req_valid_i && !req_write_i;
  assign rd_shape  = (req_len_i == 3'd4) && (req_wdata_i == 32'd0) &&
                     (req_offset_i[1:0] == 2'd0) && (read_data_i == 32'd0);

  // a stalled result holds
  `PCBR_ASSERT_NXT(a_out_hold, out_stall, out_valid_i && $stable(out_word), "stalled result changed")

  // no request: request fields are all zero
  `PCBR_ASSERT_IMP(a_req_idle_zero, req_none, req_zero, "request fields set without a request")

  // read request: full dword, aligned, no write data, not a register read
  `PCBR_ASSERT_IMP(a_req_read_shape, rd_req, rd_shape, "malformed read request")

  // from empty, a result shows up only for an item taken earlier, by way of the execute register
  `PCBR_ASSERT_IMP(a_out_from_item, $rose(out_valid_i), $past(in_acc, 2), "result without an item")

endmodule

bind pcie_config_bridge_registers_unit pcbr_checker u_pcbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .read_data_i  (out_o.read_data),
  .req_valid_i  (out_o.req_valid),
  .req_write_i  (out_o.req_write),
  .req_bus_i    (out_o.req_bus),
  .req_devfn_i  (out_o.req_devfn),
  .req_offset_i (out_o.req_offset),
  .req_wdata_i  (out_o.req_wdata),
  .req_len_i    (out_o.req_len),
  .intx_level_i (out_o.intx_level)
);
